// ===== hdl/fta_pkg.sv =====
package fta_pkg;

  localparam int FRAME_W  = 35;
  localparam int DT_W     = 34;
  localparam int RATE_W   = 10;
  localparam int TOL_W    = 24;
  localparam int MAXT_W   = 16;
  localparam int UNITS_W  = 44;
  localparam int WIN_W    = 34;
  localparam int REM_W    = 30;
  localparam int QUOT_W   = 15;
  localparam int TICKS_W  = 16;
  localparam int TOTAL_W  = 48;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 24;

  localparam logic [DT_W-1:0]    FRAME_CLAMP_NS = 34'd10000000000;
  localparam logic [REM_W-1:0]   TICK_UNITS     = 30'd1000000000;
  localparam int                 SNAP_MULTIPLES = 4;

  // floor(2^61 / 1e9), used on units[43:29]
  localparam int                 HI_SHIFT  = 29;
  localparam int                 HI_W      = UNITS_W - HI_SHIFT;
  localparam int                 RECIP_SH  = 32;
  localparam logic [31:0]        RECIP     = 32'd2305843009;
  localparam int                 PROD_W    = HI_W + 32;

  localparam logic [CIDX_W-1:0]  REG_TICK_RATE = 2'd0;
  localparam logic [CIDX_W-1:0]  REG_SNAP_TOL  = 2'd1;
  localparam logic [CIDX_W-1:0]  REG_MAX_TICKS = 2'd2;

  localparam logic [RATE_W-1:0]  TICK_RATE_RST = 10'd60;
  localparam logic [TOL_W-1:0]   SNAP_TOL_RST  = 24'd250000;
  localparam logic [MAXT_W-1:0]  MAX_TICKS_RST = 16'd8;

  typedef struct packed {
    logic [RATE_W-1:0] tick_rate_hz;
    logic [TOL_W-1:0]  snap_tolerance_ns;
    logic [MAXT_W-1:0] max_ticks_per_frame;
  } cfg_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } div_res_t;

endpackage

// ===== hdl/fta_if.sv =====
interface fta_in_if;
  import fta_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FRAME_W-1:0] frame_ns;
  modport source (output valid, output frame_ns, input ready);
  modport sink   (input valid, input frame_ns, output ready);
endinterface

interface fta_out_if;
  import fta_pkg::*;
  logic               valid;
  logic               ready;
  logic [TICKS_W-1:0] ticks_due;
  logic [TOTAL_W-1:0] total_ticks;
  logic [TOTAL_W-1:0] dropped_total;
  logic [REM_W-1:0]   remainder_units;
  modport source (output valid, output ticks_due, output total_ticks,
                  output dropped_total, output remainder_units, input ready);
  modport sink   (input valid, input ticks_due, input total_ticks,
                  input dropped_total, input remainder_units, output ready);
endinterface

interface fta_cfg_if;
  import fta_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fixed_timestep_accumulator.sv =====
// pipeline: an accepted item passes through seven register stages before its
// result is offered on out_ch
// throughput: one item per cycle unless out_ch holds ready low; the phase
// accumulator and tick totals loop on their own registers; the rest is forward
// reset: synchronous, rst_n low empties the pipeline, zeroes the accumulator
// and both totals, and loads the register defaults (60 Hz, 250 us, 8 ticks)
module fixed_timestep_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  fta_cfg_if.sink   cfg_ch,
  fta_in_if.sink    in_ch,
  fta_out_if.source out_ch
);
  import fta_pkg::*;

  cfg_t               cfg_r;
  logic               f_valid, f_ready;
  logic [UNITS_W-1:0] f_units;
  logic               d_valid, d_ready;
  div_res_t           d_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_rate_hz        <= TICK_RATE_RST;
      cfg_r.snap_tolerance_ns   <= SNAP_TOL_RST;
      cfg_r.max_ticks_per_frame <= MAX_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_TICK_RATE: cfg_r.tick_rate_hz        <= cfg_ch.data[RATE_W-1:0];
        REG_SNAP_TOL:  cfg_r.snap_tolerance_ns   <= cfg_ch.data[TOL_W-1:0];
        REG_MAX_TICKS: cfg_r.max_ticks_per_frame <= cfg_ch.data[MAXT_W-1:0];
        default: ;
      endcase
    end
  end

  fta_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_frame_ns (in_ch.frame_ns),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_units   (f_units)
  );

  fta_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_units  (f_units),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_res   (d_res)
  );

  fta_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_res   (d_res),
    .out_ch   (out_ch)
  );

endmodule

// ===== hdl/fta_front.sv =====
module fta_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fta_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [fta_pkg::FRAME_W-1:0] in_frame_ns,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fta_pkg::UNITS_W-1:0]        out_units
);
  import fta_pkg::*;

  logic               v1_r, v1_nxt, v2_r, v2_nxt;
  logic               en1, en2, mv2;
  logic [DT_W-1:0]    dt;
  logic [UNITS_W-1:0] units1_r, units1_nxt;
  logic [WIN_W-1:0]   win1_r, win1_nxt;
  logic               snap_on1_r, snap_on1_nxt;
  logic [UNITS_W-1:0] units2_r, units2_nxt;
  logic [UNITS_W-1:0] target [SNAP_MULTIPLES];
  logic [UNITS_W-1:0] diff   [SNAP_MULTIPLES];
  logic [SNAP_MULTIPLES-1:0] hit;

  assign mv2      = v2_r & out_ready;
  assign en2      = v1_r & (~v2_r | mv2);
  assign en1      = in_valid & in_ready;
  assign in_ready = ~v1_r | en2;

  assign v1_nxt = en1 ? 1'b1 : (en2 ? 1'b0 : v1_r);
  assign v2_nxt = en2 ? 1'b1 : (mv2 ? 1'b0 : v2_r);

  // clamp to 0..10 s
  always_comb begin
    if (in_frame_ns[FRAME_W-1]) begin
      dt = '0;
    end else if (in_frame_ns[DT_W-1:0] > FRAME_CLAMP_NS) begin
      dt = FRAME_CLAMP_NS;
    end else begin
      dt = in_frame_ns[DT_W-1:0];
    end
  end

  assign units1_nxt   = UNITS_W'(dt) * UNITS_W'(cfg.tick_rate_hz);
  assign win1_nxt     = WIN_W'(cfg.snap_tolerance_ns) * WIN_W'(cfg.tick_rate_hz);
  assign snap_on1_nxt = (cfg.snap_tolerance_ns != '0);

  always_comb begin
    for (int k = 0; k < SNAP_MULTIPLES; k++) begin
      target[k] = UNITS_W'(k + 1) * UNITS_W'(TICK_UNITS);
      diff[k]   = (units1_r >= target[k]) ? units1_r - target[k] : target[k] - units1_r;
      hit[k]    = snap_on1_r & (diff[k] <= UNITS_W'(win1_r));
    end
    // lowest multiple wins where windows overlap
    units2_nxt = units1_r;
    for (int k = SNAP_MULTIPLES - 1; k >= 0; k--) begin
      if (hit[k]) begin
        units2_nxt = target[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      units1_r   <= units1_nxt;
      win1_r     <= win1_nxt;
      snap_on1_r <= snap_on1_nxt;
    end
    if (en2) begin
      units2_r <= units2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_units = units2_r;

endmodule

// ===== hdl/fta_divider.sv =====
module fta_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fta_pkg::UNITS_W-1:0] in_units,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fta_pkg::div_res_t           out_res
);
  import fta_pkg::*;

  logic               v3_r, v3_nxt, v4_r, v4_nxt, v5_r, v5_nxt;
  logic               en3, en4, en5, mv5;
  logic [HI_W-1:0]    hi;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  q3_r, q4_r, q5_r, q5_nxt;
  logic [UNITS_W-1:0] units3_r;
  logic [UNITS_W-1:0] part;
  logic [31:0]        r4_r, r4_nxt;
  logic [1:0]         corr;
  logic [REM_W-1:0]   rem5_r, rem5_nxt;

  assign mv5      = v5_r & out_ready;
  assign en5      = v4_r & (~v5_r | mv5);
  assign en4      = v3_r & (~v4_r | en5);
  assign en3      = in_valid & in_ready;
  assign in_ready = ~v3_r | en4;

  assign v3_nxt = en3 ? 1'b1 : (en4 ? 1'b0 : v3_r);
  assign v4_nxt = en4 ? 1'b1 : (en5 ? 1'b0 : v4_r);
  assign v5_nxt = en5 ? 1'b1 : (mv5 ? 1'b0 : v5_r);

  // quotient estimate from the top bits, low by at most three
  assign hi   = in_units[UNITS_W-1:HI_SHIFT];
  assign prod = PROD_W'(hi) * PROD_W'(RECIP);

  assign part   = UNITS_W'(q3_r) * UNITS_W'(TICK_UNITS);
  assign r4_nxt = 32'(units3_r - part);

  always_comb begin
    if (r4_r >= 32'(3) * 32'(TICK_UNITS)) begin
      corr = 2'd3;
    end else if (r4_r >= 32'(2) * 32'(TICK_UNITS)) begin
      corr = 2'd2;
    end else if (r4_r >= 32'(TICK_UNITS)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    q5_nxt   = q4_r + QUOT_W'(corr);
    rem5_nxt = REM_W'(r4_r - 32'(corr) * 32'(TICK_UNITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      q3_r     <= prod[PROD_W-1:RECIP_SH];
      units3_r <= in_units;
    end
    if (en4) begin
      q4_r <= q3_r;
      r4_r <= r4_nxt;
    end
    if (en5) begin
      q5_r   <= q5_nxt;
      rem5_r <= rem5_nxt;
    end
  end

  assign out_valid    = v5_r;
  assign out_res.quot = q5_r;
  assign out_res.rem  = rem5_r;

endmodule

// ===== hdl/fta_accum.sv =====
module fta_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  fta_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  fta_pkg::div_res_t in_res,
  fta_out_if.source         out_ch
);
  import fta_pkg::*;

  logic               v6_r, v6_nxt, v7_r, v7_nxt;
  logic               en6, en7, mv7;
  logic [REM_W-1:0]   phase_r, phase_nxt;
  logic [REM_W:0]     sum;
  logic               carry;
  logic [TICKS_W-1:0] n6_r, n6_nxt;
  logic [REM_W-1:0]   rem6_r;
  logic [TICKS_W-1:0] rel, excess;
  logic [TICKS_W-1:0] ticks7_r;
  logic [REM_W-1:0]   rem7_r;
  logic [TOTAL_W-1:0] total_r, total_nxt, dropped_r, dropped_nxt;

  assign mv7      = v7_r & out_ch.ready;
  assign en7      = v6_r & (~v7_r | mv7);
  assign en6      = in_valid & in_ready;
  assign in_ready = ~v6_r | en7;

  assign v6_nxt = en6 ? 1'b1 : (en7 ? 1'b0 : v6_r);
  assign v7_nxt = en7 ? 1'b1 : (mv7 ? 1'b0 : v7_r);

  // both parts are below one tick, so at most one carry
  assign sum       = {1'b0, phase_r} + {1'b0, in_res.rem};
  assign carry     = (sum >= {1'b0, TICK_UNITS});
  assign phase_nxt = carry ? REM_W'(sum - {1'b0, TICK_UNITS}) : sum[REM_W-1:0];
  assign n6_nxt    = TICKS_W'(in_res.quot) + TICKS_W'(carry);

  always_comb begin
    if (n6_r > cfg.max_ticks_per_frame) begin
      rel    = cfg.max_ticks_per_frame;
      excess = n6_r - cfg.max_ticks_per_frame;
    end else begin
      rel    = n6_r;
      excess = '0;
    end
    total_nxt   = total_r + TOTAL_W'(rel);
    dropped_nxt = dropped_r + TOTAL_W'(excess);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r      <= 1'b0;
      v7_r      <= 1'b0;
      phase_r   <= '0;
      total_r   <= '0;
      dropped_r <= '0;
    end else begin
      v6_r <= v6_nxt;
      v7_r <= v7_nxt;
      if (en6) begin
        phase_r <= phase_nxt;
      end
      if (en7) begin
        total_r   <= total_nxt;
        dropped_r <= dropped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      n6_r   <= n6_nxt;
      rem6_r <= phase_nxt;
    end
    if (en7) begin
      ticks7_r <= rel;
      rem7_r   <= rem6_r;
    end
  end

  assign out_ch.valid           = v7_r;
  assign out_ch.ticks_due       = ticks7_r;
  assign out_ch.total_ticks     = total_r;
  assign out_ch.dropped_total   = dropped_r;
  assign out_ch.remainder_units = rem7_r;

endmodule
